// ===== src/dcrf_pkg.sv =====
// Shared constants, codes and item types of the drop-counting ring FIFO.
`default_nettype none
package dcrf_pkg;

    localparam int CAPACITY   = 64;
    localparam int EVENT_BITS = 64;

    // The ring is the smallest power of two not below CAPACITY, kept within 2 to 64.
    function automatic int calc_ring_size(input int want);
        int size;
        size = 2;
        for (int i = 0; i < 6; i++) begin
            if (size < want && size < 64) begin
                size = size * 2;
            end
        end
        return size;
    endfunction

    localparam int RING_SIZE  = calc_ring_size(CAPACITY);
    localparam int IDX_BITS   = $clog2(RING_SIZE);
    localparam int SEQ_BITS   = 7;
    localparam int DROP_BITS  = 32;
    localparam int DATA_BITS  = 64;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_EVENT = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    typedef struct packed {
        logic                 op;
        logic [DATA_BITS-1:0] event_data;
        logic [SEQ_BITS-1:0]  drain_max;
    } request_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 accepted;
        logic [DATA_BITS-1:0] event_out;
        logic                 last;
        logic [DROP_BITS-1:0] drops_so_far;
        logic [SEQ_BITS-1:0]  live_count;
    } result_t;

    // Commands from the controller to the datapath for the current cycle.
    typedef struct packed {
        logic push;
        logic pop;
        logic empty;
        logic last;
    } cmd_t;

endpackage
`default_nettype wire

// ===== src/drop_counting_ring_fifo.sv =====
// Top level of the drop-counting ring FIFO.
//
//   channel   handshake              payload
//   request   start & !busy          request (op, event_data, drain_max)
//   result    strobe, one cycle      result (kind, accepted, event_out, last, ...)
//
// A push's acknowledgement appears in the cycle after the push is taken;
// pushes may follow each other every cycle.
// A drain that removes n events holds busy while it pops all but the first event,
// and emits one event per cycle, paced by the single read port of the slot memory.
// Reset clears the sequence counters and the drop counter; slot contents are not cleared.
// Results cannot be stalled: each one is valid for exactly one cycle.
`default_nettype none
module drop_counting_ring_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire dcrf_pkg::request_t request,
    output logic                    busy,
    output logic                    strobe,
    output dcrf_pkg::result_t       result
);

    dcrf_pkg::cmd_t                cmd;
    logic [dcrf_pkg::SEQ_BITS-1:0] live;

    dcrf_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (request.op),
        .drain_max (request.drain_max),
        .live      (live),
        .busy      (busy),
        .cmd       (cmd)
    );

    dcrf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .event_data (request.event_data),
        .live       (live),
        .strobe     (strobe),
        .result     (result)
    );

endmodule
`default_nettype wire

// ===== src/dcrf_datapath.sv =====
// Ring storage, sequence counters, drop counter and result registers.
`default_nettype none
module dcrf_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dcrf_pkg::cmd_t                  cmd,
    input  wire logic [dcrf_pkg::DATA_BITS-1:0]  event_data,
    output logic [dcrf_pkg::SEQ_BITS-1:0]        live,
    output logic                                 strobe,
    output dcrf_pkg::result_t                    result
);

    logic [dcrf_pkg::EVENT_BITS-1:0] mem [dcrf_pkg::RING_SIZE];
    logic [dcrf_pkg::EVENT_BITS-1:0] rd_data_reg;

    logic [dcrf_pkg::SEQ_BITS-1:0]  write_seq_reg, write_seq_next;
    logic [dcrf_pkg::SEQ_BITS-1:0]  read_seq_reg, read_seq_next;
    logic [dcrf_pkg::DROP_BITS-1:0] drop_reg, drop_next;

    logic                           strobe_reg;
    logic [1:0]                     kind_reg, kind_next;
    logic                           accepted_reg, accepted_next;
    logic                           last_reg;
    logic [dcrf_pkg::SEQ_BITS-1:0]  live_out_reg, live_out_next;

    logic full;
    logic do_write;

    assign live     = write_seq_reg - read_seq_reg;
    assign full     = live >= dcrf_pkg::SEQ_BITS'(dcrf_pkg::RING_SIZE);
    assign do_write = cmd.push && !full;

    always_comb
    begin
        write_seq_next = write_seq_reg;
        read_seq_next  = read_seq_reg;
        drop_next      = drop_reg;
        kind_next      = dcrf_pkg::KIND_ACK;
        accepted_next  = 1'b0;
        live_out_next  = live;
        if (cmd.push) begin
            if (full) begin
                drop_next = drop_reg + 1'b1;
            end else begin
                write_seq_next = write_seq_reg + 1'b1;
                accepted_next  = 1'b1;
                live_out_next  = live + 1'b1;
            end
        end else if (cmd.pop) begin
            read_seq_next = read_seq_reg + 1'b1;
            kind_next     = dcrf_pkg::KIND_EVENT;
            live_out_next = live - 1'b1;
        end else if (cmd.empty) begin
            kind_next = dcrf_pkg::KIND_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write) begin
            mem[write_seq_reg[dcrf_pkg::IDX_BITS-1:0]] <=
                event_data[dcrf_pkg::EVENT_BITS-1:0];
        end
        // The slot at the read position is fetched every cycle; a pop shows it next cycle.
        rd_data_reg <= mem[read_seq_reg[dcrf_pkg::IDX_BITS-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            write_seq_reg <= '0;
            read_seq_reg  <= '0;
            drop_reg      <= '0;
            strobe_reg    <= 1'b0;
        end else begin
            write_seq_reg <= write_seq_next;
            read_seq_reg  <= read_seq_next;
            drop_reg      <= drop_next;
            strobe_reg    <= cmd.push || cmd.pop || cmd.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        accepted_reg <= accepted_next;
        last_reg     <= cmd.push || cmd.empty || cmd.last;
        live_out_reg <= live_out_next;
    end

    always_comb
    begin
        result.kind         = kind_reg;
        result.accepted     = accepted_reg;
        result.event_out    = '0;
        if (kind_reg == dcrf_pkg::KIND_EVENT) begin
            result.event_out = dcrf_pkg::DATA_BITS'(rd_data_reg);
        end
        result.last         = last_reg;
        result.drops_so_far = drop_reg;
        result.live_count   = live_out_reg;
    end

    assign strobe = strobe_reg;

endmodule
`default_nettype wire

// ===== src/dcrf_controller.sv =====
// Sequencer that turns push and drain items into per-cycle datapath commands.
`default_nettype none
module dcrf_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic                           op,
    input  wire logic [dcrf_pkg::SEQ_BITS-1:0]  drain_max,
    input  wire logic [dcrf_pkg::SEQ_BITS-1:0]  live,
    output logic                                busy,
    output dcrf_pkg::cmd_t                      cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t                        state_reg, state_next;
    logic [dcrf_pkg::SEQ_BITS-1:0] remain_reg, remain_next;
    logic [dcrf_pkg::SEQ_BITS-1:0] take;

    assign take = (live < drain_max) ? live : drain_max;

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    if (op == dcrf_pkg::OP_PUSH) begin
                        cmd.push = 1'b1;
                    end else if (take == '0) begin
                        cmd.empty = 1'b1;
                    end else begin
                        // The first event is popped in the same cycle the item is taken.
                        cmd.pop     = 1'b1;
                        cmd.last    = take == dcrf_pkg::SEQ_BITS'(1);
                        remain_next = take - 1'b1;
                        if (take != dcrf_pkg::SEQ_BITS'(1)) begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                cmd.pop     = 1'b1;
                cmd.last    = remain_reg == dcrf_pkg::SEQ_BITS'(1);
                remain_next = remain_reg - 1'b1;
                if (cmd.last) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    assign busy = state_reg == ST_DRAIN;

endmodule
`default_nettype wire
